/* hdl/fcba_pkg.sv */
// ---------------------------------------------------------------------------
// fcba_pkg
// Shared types, codes and constants of the chained block allocator.
// ---------------------------------------------------------------------------
package fcba_pkg;

    // default geometry
    localparam int NUM_BLOCKS_DEF   = 256;
    localparam int DIR_ENTRIES_DEF  = 16;
    localparam int RESERVED_DEF     = 4;

    // fixed field widths
    localparam int CMD_W = 3;
    localparam int KEY_W = 32;
    localparam int BN_W  = 8;
    localparam int ST_W  = 3;
    localparam int VAL_W = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_APPEND = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_NEXT   = 3'd4,
        CMD_FIRST  = 3'd5
    } t_cmd_code;

    typedef enum logic [ST_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOFILE   = 3'd1,
        ST_EXISTS   = 3'd2,
        ST_DIRFULL  = 3'd3,
        ST_NOTIN    = 3'd4,
        ST_NOTEMPTY = 3'd5,
        ST_DISKFULL = 3'd6
    } t_status;

    // datapath operations, one per cycle
    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_SCAN,
        DP_CREATE,
        DP_REMOVE,
        DP_HEAD_RD,
        DP_ALLOC_RD,
        DP_POP,
        DP_TERM,
        DP_TAIL_STEP,
        DP_TAIL_LINK,
        DP_WALK_START,
        DP_WALK_STEP,
        DP_UNLINK,
        DP_PUSH
    } t_dp_op;

    typedef enum logic [1:0] {
        VAL_ZERO,
        VAL_ALLOC,
        VAL_FIRST,
        VAL_RDATA
    } t_val_sel;

    // controller to datapath
    typedef struct packed {
        t_dp_op   op;
        logic     head_set;
        logic     set_res;
        t_status  res_status;
        t_val_sel val_sel;
        logic     publish;
    } t_dp_ctrl;

    // datapath to controller
    typedef struct packed {
        t_cmd_code cmd;
        logic      init_last;
        logic      scan_last;
        logic      found;
        logic      free_ok;
        logic      first_zero;
        logic      alloc_bad;
        logic      tail_more;
        logic      walk_end;
        logic      walk_hit;
    } t_dp_stat;

    // reset contents of one link table entry
    function automatic int init_link(input int x, input int nb, input int rsv);
        int start;
        start = rsv + 2;
        if (x == 0)
            init_link = (start < nb) ? start : 0;
        else if (x < start)
            init_link = 1;
        else
            init_link = (x + 1 < nb) ? x + 1 : 0;
    endfunction

endpackage

/* hdl/fcba_if.sv */
// ---------------------------------------------------------------------------
// fcba_if
// Command and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface fcba_cmd_if import fcba_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] file_key;
    logic [BN_W-1:0]  block_number;

    modport source (output valid, command, file_key, block_number, input ready);
    modport sink   (input valid, command, file_key, block_number, output ready);
endinterface

interface fcba_res_if import fcba_pkg::*;;
    logic             valid;
    logic             ready;
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;

    modport source (output valid, status, value, input ready);
    modport sink   (input valid, status, value, output ready);
endinterface

/* hdl/fat_chain_block_allocator_top.sv */
// Create, remove and first block finish after the directory scan; append and
//   the walk commands then follow the chain one link at a time through the
//   one-port link table.
// Throughput: one transaction at a time; the next is taken once the result
//   is in the output register. After reset the link table is rebuilt in a
//   clearing pass during which no transaction is taken.
// ---------------------------------------------------------------------------
// fat_chain_block_allocator_top
// File allocation table engine with root directory and linked free list.
// ---------------------------------------------------------------------------
module fat_chain_block_allocator_top import fcba_pkg::*; #(
    parameter int NUM_BLOCKS            = NUM_BLOCKS_DEF,
    parameter int DIR_ENTRIES           = DIR_ENTRIES_DEF,
    parameter int RESERVED_TABLE_BLOCKS = RESERVED_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fcba_cmd_if.sink    i_cmd,
    fcba_res_if.source  o_res
);

    t_dp_ctrl ctrl;
    t_dp_stat stat;

    // sequencer
    fcba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .i_stat      (stat),
        .o_ctrl      (ctrl)
    );

    // tables and working registers
    fcba_dp #(
        .NUM_BLOCKS            (NUM_BLOCKS),
        .DIR_ENTRIES           (DIR_ENTRIES),
        .RESERVED_TABLE_BLOCKS (RESERVED_TABLE_BLOCKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (ctrl),
        .i_command      (i_cmd.command),
        .i_file_key     (i_cmd.file_key),
        .i_block_number (i_cmd.block_number),
        .o_stat         (stat),
        .o_status       (o_res.status),
        .o_value        (o_res.value)
    );

endmodule

/* hdl/fcba_dp.sv */
// ---------------------------------------------------------------------------
// fcba_dp
// Datapath: link table memory, root directory and chain walk registers.
// ---------------------------------------------------------------------------
module fcba_dp import fcba_pkg::*; #(
    parameter int NUM_BLOCKS            = NUM_BLOCKS_DEF,
    parameter int DIR_ENTRIES           = DIR_ENTRIES_DEF,
    parameter int RESERVED_TABLE_BLOCKS = RESERVED_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_ctrl         i_ctrl,
    input  logic [CMD_W-1:0] i_command,
    input  logic [KEY_W-1:0] i_file_key,
    input  logic [BN_W-1:0]  i_block_number,
    output t_dp_stat         o_stat,
    output logic [ST_W-1:0]  o_status,
    output logic [VAL_W-1:0] o_value
);

    localparam int LW = $clog2(NUM_BLOCKS);
    localparam int NW = LW + 1;
    localparam int DW = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int CW = (LW > BN_W) ? LW : BN_W;

    // link table memory
    logic [LW-1:0] mem [NUM_BLOCKS];
    logic [LW-1:0] r_rdata;
    logic [LW-1:0] rd_addr;
    logic [LW-1:0] wr_addr;
    logic [LW-1:0] wr_data;
    logic          wr_en;

    // root directory
    logic             r_dir_valid [DIR_ENTRIES];
    logic [KEY_W-1:0] r_dir_key   [DIR_ENTRIES];
    logic [LW-1:0]    r_dir_first [DIR_ENTRIES];

    // working registers
    logic [LW-1:0]    r_idx;
    logic [CMD_W-1:0] r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [BN_W-1:0]  r_bn;
    logic [DW-1:0]    r_scan;
    logic             r_found;
    logic [DW-1:0]    r_e;
    logic             r_free_ok;
    logic [DW-1:0]    r_free;
    logic [LW-1:0]    r_first;
    logic [LW-1:0]    r_alloc;
    logic [LW-1:0]    r_b;
    logic [LW-1:0]    r_prev;
    logic [NW-1:0]    r_n;
    logic [ST_W-1:0]  r_res_status;
    logic [LW-1:0]    r_res_value;
    logic [ST_W-1:0]  r_out_status;
    logic [VAL_W-1:0] r_out_value;
    logic [LW-1:0]    res_val;
    logic             scan_hit;
    logic             b_in_range;
    logic             n_in_range;

    assign scan_hit   = r_dir_valid[r_scan] && (r_dir_key[r_scan] == r_key);
    assign b_in_range = {1'b0, r_b} < NW'(NUM_BLOCKS);
    assign n_in_range = r_n < NW'(NUM_BLOCKS);

    // memory port selection
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        rd_addr = '0;
        case (i_ctrl.op)
            DP_INIT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = LW'(init_link(int'(r_idx), NUM_BLOCKS, RESERVED_TABLE_BLOCKS));
            end
            DP_HEAD_RD:   rd_addr = '0;
            DP_ALLOC_RD:  rd_addr = r_rdata;
            DP_POP: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = r_rdata;
            end
            DP_TERM: begin
                wr_en   = 1'b1;
                wr_addr = r_alloc;
                wr_data = '0;
                rd_addr = r_first;
            end
            DP_TAIL_STEP: rd_addr = r_rdata;
            DP_TAIL_LINK: begin
                wr_en   = b_in_range;
                wr_addr = r_b;
                wr_data = r_alloc;
            end
            DP_WALK_START: rd_addr = r_first;
            DP_WALK_STEP:  rd_addr = r_rdata;
            DP_UNLINK: begin
                wr_en   = (r_prev != '0);
                wr_addr = r_prev;
                wr_data = r_rdata;
                rd_addr = '0;
            end
            DP_PUSH: begin
                wr_en   = 1'b1;
                wr_addr = r_b;
                wr_data = r_rdata;
            end
            default: begin
                // head update of a delete rides on a no-op cycle
                if (i_ctrl.head_set) begin
                    wr_en   = 1'b1;
                    wr_addr = '0;
                    wr_data = r_b;
                end
            end
        endcase
    end

    // link table, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rdata <= mem[rd_addr];
    end

    // clearing pass counter and directory valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int i = 0; i < DIR_ENTRIES; i++) begin
                r_dir_valid[i] <= 1'b0;
            end
        end else begin
            if (i_ctrl.op == DP_INIT) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_ctrl.op == DP_CREATE) begin
                r_dir_valid[r_free] <= 1'b1;
            end
            if (i_ctrl.op == DP_REMOVE) begin
                r_dir_valid[r_e] <= 1'b0;
            end
        end
    end

    // result value source
    always_comb begin
        case (i_ctrl.val_sel)
            VAL_ALLOC: res_val = r_alloc;
            VAL_FIRST: res_val = r_first;
            VAL_RDATA: res_val = r_rdata;
            default:   res_val = '0;
        endcase
    end

    // working registers and directory payload
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            DP_LOAD: begin
                r_cmd     <= i_command;
                r_key     <= i_file_key;
                r_bn      <= i_block_number;
                r_scan    <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
                r_first   <= '0;
            end
            DP_SCAN: begin
                if (!r_found && scan_hit) begin
                    r_found <= 1'b1;
                    r_e     <= r_scan;
                    r_first <= r_dir_first[r_scan];
                end
                if (!r_free_ok && !r_dir_valid[r_scan]) begin
                    r_free_ok <= 1'b1;
                    r_free    <= r_scan;
                end
                r_scan <= r_scan + 1'b1;
            end
            DP_CREATE: begin
                r_dir_key[r_free]   <= r_key;
                r_dir_first[r_free] <= '0;
            end
            DP_ALLOC_RD: r_alloc <= r_rdata;
            DP_TERM: begin
                if (r_first == '0) begin
                    r_dir_first[r_e] <= r_alloc;
                end
                r_b <= r_first;
                r_n <= '0;
            end
            DP_TAIL_STEP: begin
                r_b <= r_rdata;
                r_n <= r_n + 1'b1;
            end
            DP_WALK_START: begin
                r_b    <= r_first;
                r_prev <= '0;
                r_n    <= '0;
            end
            DP_WALK_STEP: begin
                r_prev <= r_b;
                r_b    <= r_rdata;
                r_n    <= r_n + 1'b1;
            end
            DP_UNLINK: begin
                if (r_prev == '0) begin
                    r_dir_first[r_e] <= r_rdata;
                end
            end
            default: ;
        endcase
        if (i_ctrl.set_res) begin
            r_res_status <= i_ctrl.res_status;
            r_res_value  <= res_val;
        end
        if (i_ctrl.publish) begin
            r_out_status <= r_res_status;
            r_out_value  <= VAL_W'(r_res_value);
        end
    end

    // status towards the controller
    always_comb begin
        o_stat.cmd        = t_cmd_code'(r_cmd);
        o_stat.init_last  = (r_idx == LW'(NUM_BLOCKS - 1));
        o_stat.scan_last  = (r_scan == DW'(DIR_ENTRIES - 1));
        o_stat.found      = r_found;
        o_stat.free_ok    = r_free_ok;
        o_stat.first_zero = (r_first == '0);
        o_stat.alloc_bad  = (r_rdata == '0) || ({1'b0, r_rdata} >= NW'(NUM_BLOCKS));
        o_stat.tail_more  = n_in_range && b_in_range && (r_rdata != '0);
        o_stat.walk_end   = !(n_in_range && (r_b != '0) && b_in_range);
        o_stat.walk_hit   = (CW'(r_b) == CW'(r_bn));
    end

    assign o_status = r_out_status;
    assign o_value  = r_out_value;

endmodule

/* hdl/fcba_ctrl.sv */
// ---------------------------------------------------------------------------
// fcba_ctrl
// Controller: sequences directory scan, allocation and chain walks.
// ---------------------------------------------------------------------------
module fcba_ctrl import fcba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_dp_ctrl o_ctrl
);

    typedef enum logic [11:0] {
        S_INIT = 12'b0000_0000_0001,
        S_IDLE = 12'b0000_0000_0010,
        S_SCAN = 12'b0000_0000_0100,
        S_EXEC = 12'b0000_0000_1000,
        S_HEAD = 12'b0000_0001_0000,
        S_POP  = 12'b0000_0010_0000,
        S_TERM = 12'b0000_0100_0000,
        S_TAIL = 12'b0000_1000_0000,
        S_WALK = 12'b0001_0000_0000,
        S_PUSH = 12'b0010_0000_0000,
        S_HSET = 12'b0100_0000_0000,
        S_FIN  = 12'b1000_0000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // next state and datapath command
    always_comb begin
        n_state           = r_state;
        o_ctrl.op         = DP_NOP;
        o_ctrl.head_set   = 1'b0;
        o_ctrl.set_res    = 1'b0;
        o_ctrl.res_status = ST_OK;
        o_ctrl.val_sel    = VAL_ZERO;
        o_ctrl.publish    = 1'b0;
        o_in_ready        = 1'b0;
        case (r_state)
            S_INIT: begin
                o_ctrl.op = DP_INIT;
                if (i_stat.init_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctrl.op = DP_LOAD;
                    n_state   = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctrl.op = DP_SCAN;
                if (i_stat.scan_last) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_ctrl.set_res = 1'b1;
                n_state        = S_FIN;
                case (i_stat.cmd)
                    CMD_CREATE: begin
                        if (i_stat.found) begin
                            o_ctrl.res_status = ST_EXISTS;
                        end else if (i_stat.free_ok) begin
                            o_ctrl.op = DP_CREATE;
                        end else begin
                            o_ctrl.res_status = ST_DIRFULL;
                        end
                    end
                    CMD_REMOVE: begin
                        if (!i_stat.found) begin
                            o_ctrl.res_status = ST_NOFILE;
                        end else if (!i_stat.first_zero) begin
                            o_ctrl.res_status = ST_NOTEMPTY;
                        end else begin
                            o_ctrl.op = DP_REMOVE;
                        end
                    end
                    CMD_APPEND: begin
                        if (!i_stat.found) begin
                            o_ctrl.res_status = ST_NOFILE;
                        end else begin
                            o_ctrl.set_res = 1'b0;
                            o_ctrl.op      = DP_HEAD_RD;
                            n_state        = S_HEAD;
                        end
                    end
                    CMD_DELETE, CMD_NEXT: begin
                        if (!i_stat.found) begin
                            o_ctrl.res_status = ST_NOFILE;
                        end else begin
                            o_ctrl.set_res = 1'b0;
                            o_ctrl.op      = DP_WALK_START;
                            n_state        = S_WALK;
                        end
                    end
                    CMD_FIRST: begin
                        if (!i_stat.found) begin
                            o_ctrl.res_status = ST_NOFILE;
                        end else begin
                            o_ctrl.val_sel = VAL_FIRST;
                        end
                    end
                    default: ;
                endcase
            end
            // free list head is in the read register
            S_HEAD: begin
                if (i_stat.alloc_bad) begin
                    o_ctrl.set_res    = 1'b1;
                    o_ctrl.res_status = ST_DISKFULL;
                    n_state           = S_FIN;
                end else begin
                    o_ctrl.op = DP_ALLOC_RD;
                    n_state   = S_POP;
                end
            end
            S_POP: begin
                o_ctrl.op = DP_POP;
                n_state   = S_TERM;
            end
            S_TERM: begin
                o_ctrl.op = DP_TERM;
                if (i_stat.first_zero) begin
                    o_ctrl.set_res = 1'b1;
                    o_ctrl.val_sel = VAL_ALLOC;
                    n_state        = S_FIN;
                end else begin
                    n_state = S_TAIL;
                end
            end
            // walk to the tail of the chain, one link a cycle
            S_TAIL: begin
                if (i_stat.tail_more) begin
                    o_ctrl.op = DP_TAIL_STEP;
                end else begin
                    o_ctrl.op      = DP_TAIL_LINK;
                    o_ctrl.set_res = 1'b1;
                    o_ctrl.val_sel = VAL_ALLOC;
                    n_state        = S_FIN;
                end
            end
            // membership walk, one link a cycle
            S_WALK: begin
                if (i_stat.walk_end) begin
                    o_ctrl.set_res    = 1'b1;
                    o_ctrl.res_status = ST_NOTIN;
                    n_state           = S_FIN;
                end else if (i_stat.walk_hit) begin
                    if (i_stat.cmd == CMD_NEXT) begin
                        o_ctrl.set_res = 1'b1;
                        o_ctrl.val_sel = VAL_RDATA;
                        n_state        = S_FIN;
                    end else begin
                        o_ctrl.op = DP_UNLINK;
                        n_state   = S_PUSH;
                    end
                end else begin
                    o_ctrl.op = DP_WALK_STEP;
                end
            end
            S_PUSH: begin
                o_ctrl.op = DP_PUSH;
                n_state   = S_HSET;
            end
            S_HSET: begin
                o_ctrl.head_set = 1'b1;
                o_ctrl.set_res  = 1'b1;
                n_state         = S_FIN;
            end
            // hand the result over once the output register is free
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    o_ctrl.publish = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    // output valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_ctrl.publish)   n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* hdl/fcba_checker.sv */
// ---------------------------------------------------------------------------
// fcba_checker
// Port level checks of the allocator, bound to the top level.
// ---------------------------------------------------------------------------
module fcba_checker import fcba_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_cmd_ready,
    input logic             i_res_valid,
    input logic             i_res_ready,
    input logic [ST_W-1:0]  i_res_status,
    input logic [VAL_W-1:0] i_res_value
);

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_status <= ST_DISKFULL))
        else $error("status code out of range");

    // every error carries a zero value
    a_error_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_res_status != ST_OK) |-> (i_res_value == '0))
        else $error("nonzero value on an error");

    // command ready is low right after reset, at the start of the clearing pass
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_cmd_ready)
        else $error("ready right after reset");

    // a stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=>
            (i_res_valid && $stable(i_res_status) && $stable(i_res_value)))
        else $error("stalled result changed");

endmodule

bind fat_chain_block_allocator_top fcba_checker u_fcba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_value  (o_res.value)
);
